### rtl/rsfd_pkg.sv
// Shared types, codes and a helper function for the range sensor frame decoder.
`default_nettype none

package rsfd_pkg;

    localparam int unsigned HistDepth  = 3;
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned RangeW     = 12;
    localparam int unsigned AngleW     = 13;

    typedef logic [1:0] status_t;

    localparam status_t StatusOk       = 2'd0;
    localparam status_t StatusChecksum = 2'd1;
    localparam status_t StatusRange    = 2'd2;
    localparam status_t StatusShort    = 2'd3;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CfgRangeMin = 2'd0;
    localparam cfg_index_t CfgRangeMax = 2'd1;

    // One classified frame handed from the front end to the back end.
    typedef struct packed {
        logic       short_frame;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } job_t;

    function automatic logic [3:0] bit_count8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/rsfd_front.sv
// Front end: keeps the byte history and turns each end byte into a frame job.
`default_nettype none

module rsfd_front
    import rsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    output      logic       job_push,
    output      job_t       job
);

    logic [7:0] hist_reg [HistDepth];
    logic [7:0] hist_next [HistDepth];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       end_byte;
    logic       have_all;

    assign end_byte = rx_byte[7];
    assign have_all = (count_reg == 2'(HistDepth));

    always_comb
    begin
        hist_next  = hist_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (!end_byte)
            begin
                if (!have_all)
                begin
                    hist_next[count_reg] = rx_byte;
                    count_next           = count_reg + 2'd1;
                end
                else
                begin
                    hist_next[0] = hist_reg[1];
                    hist_next[1] = hist_reg[2];
                    hist_next[2] = rx_byte;
                end
            end
            else if (!have_all)
            begin
                // Short frame: the end byte starts a fresh history.
                hist_next[0] = rx_byte;
                hist_next[1] = 8'd0;
                hist_next[2] = 8'd0;
                count_next   = 2'd1;
            end
            else
            begin
                hist_next[0] = 8'd0;
                hist_next[1] = 8'd0;
                hist_next[2] = 8'd0;
                count_next   = 2'd0;
            end
        end
    end

    assign job_push        = accept && end_byte;
    assign job.short_frame = !have_all;
    assign job.b0          = hist_reg[0];
    assign job.b1          = hist_reg[1];
    assign job.b2          = hist_reg[2];
    assign job.b3          = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            for (int i = 0; i < HistDepth; i++)
            begin
                hist_reg[i] <= 8'd0;
            end
        end
        else
        begin
            count_reg <= count_next;
            hist_reg  <= hist_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rsfd_queue.sv
// Short job queue that decouples the front end from the back end.
`default_nettype none

module rsfd_queue
    import rsfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output      logic full,
    input  wire logic pop,
    output      logic valid,
    output      job_t head
);

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    job_t            mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(QueueDepth));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rsfd_back.sv
// Back end: checksum, code assembly, range check and the result register.
`default_nettype none

module rsfd_back
    import rsfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    input  wire job_t              job,
    output      logic              job_pop,
    input  wire logic [RangeW-1:0] range_min,
    input  wire logic [RangeW-1:0] range_max,
    output      logic              empty,
    input  wire logic              pop,
    output      logic [1:0]        status,
    output      logic [RangeW-1:0] range_code,
    output      logic [AngleW-1:0] angle_code
);

    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [RangeW-1:0] range_reg;
    logic [RangeW-1:0] range_next;
    logic [AngleW-1:0] angle_reg;
    logic [AngleW-1:0] angle_next;
    logic [4:0]        ones;
    logic [RangeW-1:0] rng;
    logic [AngleW-1:0] ang;

    assign job_pop = job_valid && (!out_valid_reg || pop);

    assign ones = 5'(bit_count8(job.b1)) + 5'(bit_count8(job.b2)) + 5'(bit_count8(job.b3));
    assign rng  = {job.b0[3:0], job.b1[6:0], job.b2[6]};
    assign ang  = {job.b2[5:0], job.b3[6:0]};

    always_comb
    begin
        range_next = rng;
        angle_next = ang;
        priority if (job.short_frame)
        begin
            status_next = StatusShort;
            range_next  = '0;
            angle_next  = '0;
        end
        else if (ones[2:0] != job.b0[6:4])
        begin
            status_next = StatusChecksum;
        end
        else if ((rng < range_min) || (rng > range_max))
        begin
            status_next = StatusRange;
        end
        else
        begin
            status_next = StatusOk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            status_reg <= status_next;
            range_reg  <= range_next;
            angle_reg  <= angle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (job_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign empty      = !out_valid_reg;
    assign status     = status_reg;
    assign range_code = range_reg;
    assign angle_code = angle_reg;

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> out_valid_reg)
        else $error("result register not loaded after taking a job");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == StatusShort)) |-> (range_reg == '0 && angle_reg == '0))
        else $error("short frame result carries non-zero codes");

    a_ok_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop && (status_next == StatusOk)) |->
            (rng >= range_min && rng <= range_max && !job.short_frame))
        else $error("frame reported good outside the range limits");

endmodule

`default_nettype wire

### rtl/range_sensor_frame_decoder_top.sv
// Top level of the range sensor frame decoder: front end, job queue, back end.
//
//  Channel   Handshake          Payload                            Direction
//  input     push / full        rx_byte[7:0]                       in
//  result    empty / pop        status[1:0], range_code[11:0],     out
//                               angle_code[12:0]
//  config    cfg_valid/ready    cfg_index[1:0], cfg_data[11:0]     in
//
// One byte is accepted per cycle, back to back, while the queue is not full; an
// end byte's result passes through the job queue and then the result register.
// The rate is set by the history update in the front end.
// Reset (rst_n, asynchronous, active low) clears the history, the queue and the
// result register, and loads range_min with 3 and range_max with 819.
// When results are not popped the two-entry queue fills and full rises; plain
// data bytes are then held off as well, so byte order is preserved.
`default_nettype none

module range_sensor_frame_decoder_top
    import rsfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output      logic              full,
    input  wire logic [7:0]        rx_byte,
    output      logic              empty,
    input  wire logic              pop,
    output      logic [1:0]        status,
    output      logic [RangeW-1:0] range_code,
    output      logic [AngleW-1:0] angle_code,
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [RangeW-1:0] cfg_data
);

    logic              accept;
    logic              job_push;
    job_t              job_in;
    logic              job_valid;
    job_t              job_head;
    logic              job_pop;
    logic [RangeW-1:0] range_min_reg;
    logic [RangeW-1:0] range_max_reg;

    // A register write is always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= RangeW'(3);
            range_max_reg <= RangeW'(819);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CfgRangeMin: range_min_reg <= cfg_data;
                CfgRangeMax: range_max_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Every byte transaction waits while the queue is full, which keeps the
    // history in step with the frames still waiting in the back end.
    assign accept = push && !full;

    rsfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .job_push (job_push),
        .job      (job_in)
    );

    rsfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (full),
        .pop       (job_pop),
        .valid     (job_valid),
        .head      (job_head)
    );

    rsfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job_head),
        .job_pop    (job_pop),
        .range_min  (range_min_reg),
        .range_max  (range_max_reg),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .range_code (range_code),
        .angle_code (angle_code)
    );

endmodule

`default_nettype wire

### tb/sv/range_sensor_frame_decoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the range sensor frame decoder: byte stimulus, limit writes, frame checks.

import rsfd_pkg::*;

// One decoded frame report as the block should present it.
typedef struct packed {
    status_t     status;
    logic [11:0] rng;
    logic [12:0] ang;
} frame_report_t;

// Tracks the decoder's byte history and limits, and holds the reports still owed.
class frame_ledger;
    logic [11:0]   range_min;
    logic [11:0]   range_max;
    logic [7:0]    hist [3];
    int unsigned   held;
    frame_report_t expected_reports [$];
    int            failures;

    function new();
        range_min = 12'd3;
        range_max = 12'd819;
        hist      = '{default: 8'h00};
        held      = 0;
        failures  = 0;
    endfunction

    function void write_limit(cfg_index_t idx, logic [11:0] value);
        case (idx)
            CfgRangeMin: range_min = value;
            CfgRangeMax: range_max = value;
            default: ;
        endcase
    endfunction

    function void take_byte(logic [7:0] b);
        frame_report_t rep;
        logic [2:0]    sum;
        if (!b[7])
        begin
            if (held < 3)
            begin
                hist[held] = b;
                held++;
            end
            else
            begin
                hist[0] = hist[1];
                hist[1] = hist[2];
                hist[2] = b;
            end
            return;
        end
        if (held < 3)
        begin
            // A short frame keeps its end byte as the start of the next history.
            rep.status = StatusShort;
            rep.rng    = '0;
            rep.ang    = '0;
            hist       = '{b, 8'h00, 8'h00};
            held       = 1;
        end
        else
        begin
            sum     = 3'($countones(hist[1]) + $countones(hist[2]) + $countones(b));
            rep.rng = {hist[0][3:0], hist[1][6:0], hist[2][6]};
            rep.ang = {hist[2][5:0], b[6:0]};
            if (sum != hist[0][6:4])
                rep.status = StatusChecksum;
            else if (rep.rng < range_min || rep.rng > range_max)
                rep.status = StatusRange;
            else
                rep.status = StatusOk;
            hist = '{default: 8'h00};
            held = 0;
        end
        expected_reports.push_back(rep);
    endfunction

    function void check_report(status_t st, logic [11:0] r, logic [12:0] a);
        frame_report_t want;
        if (expected_reports.size() == 0)
        begin
            $display("%0t: unexpected report: status %0d range %0d angle %0d",
                     $time, st, r, a);
            failures++;
            return;
        end
        want = expected_reports.pop_front();
        if (st !== want.status)
        begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, st);
            failures++;
        end
        if (r !== want.rng)
        begin
            $display("%0t: range_code expected %0d, actual %0d", $time, want.rng, r);
            failures++;
        end
        if (a !== want.ang)
        begin
            $display("%0t: angle_code expected %0d, actual %0d", $time, want.ang, a);
            failures++;
        end
    endfunction
endclass

module range_sensor_frame_decoder_top_test;

    // Register indexes beyond the two limits; the block must ignore writes to them.
    localparam cfg_index_t CfgSpareLow  = 2'd2;
    localparam cfg_index_t CfgSpareHigh = 2'd3;

    // Cycles with no transaction at all before the run is declared hung.
    localparam int WatchdogLimit = 2000;
    // Quiet cycles after the last report, so that a stray late report is still seen.
    localparam int SettleCycles  = 8;
    // Random bytes sent under each limit setting.
    localparam int PhaseBytes    = 115;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    logic [7:0]        rx_byte   = 8'h00;
    logic              pop       = 1'b0;
    logic              cfg_valid = 1'b0;
    cfg_index_t        cfg_index = CfgRangeMin;
    logic [RangeW-1:0] cfg_data  = '0;

    logic              full;
    logic              empty;
    logic              cfg_ready;
    logic [1:0]        status;
    logic [RangeW-1:0] range_code;
    logic [AngleW-1:0] angle_code;

    frame_ledger ledger = new();

    // When set, neither side inserts gaps, so bytes and pops run back to back.
    bit steady         = 1'b0;
    int push_gap_left  = 0;
    int pop_stall_left = 0;
    int bytes_sent     = 0;
    int idle_cycles    = 0;

    range_sensor_frame_decoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .range_code (range_code),
        .angle_code (angle_code),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Every report popped from the block is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            ledger.check_report(status, range_code, angle_code);
    end

    // The watchdog restarts on any transaction, on any channel; a long silence
    // means the block has stopped answering.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WatchdogLimit)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // The result side pops on most cycles. Stalls come in short runs, so that the
    // two-entry queue inside the block fills now and then and full rises.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!steady && pop_stall_left == 0 && $urandom_range(0, 99) < 5)
                pop_stall_left = $urandom_range(1, 8);
            if (pop_stall_left > 0)
            begin
                pop <= 1'b0;
                pop_stall_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // Called at a falling edge; returns at a falling edge with push left high, so
    // that a following byte keeps push up without a low pulse in between. While
    // idle, rx_byte carries junk which the block must not take.
    task automatic send_byte(input logic [7:0] b);
        if (!steady && push_gap_left == 0 && $urandom_range(0, 99) < 5)
            push_gap_left = $urandom_range(1, 8);
        while (push_gap_left > 0)
        begin
            push    <= 1'b0;
            rx_byte <= 8'($urandom);
            @(negedge clk);
            push_gap_left--;
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        ledger.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Builds a four-byte frame, oldest byte in the top byte lane. With a bad
    // checksum the field is flipped in at least one bit.
    function automatic logic [31:0] pack_frame(input logic [11:0] r, input logic [12:0] a,
                                               input bit good);
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] cs;
        b1 = {1'b0, r[7:1]};
        b2 = {1'b0, r[0], a[12:7]};
        b3 = {1'b1, a[6:0]};
        cs = 3'($countones(b1) + $countones(b2) + $countones(b3));
        if (!good)
            cs = cs ^ 3'($urandom_range(1, 7));
        return {1'b0, cs, r[11:8], b1, b2, b3};
    endfunction

    task automatic send_frame(input logic [11:0] r, input logic [12:0] a, input bit good);
        logic [31:0] frame;
        frame = pack_frame(r, a, good);
        for (int i = 3; i >= 0; i--)
            send_byte(frame[i*8 +: 8]);
    endtask

    // Config transaction; issued only while the block is drained.
    task automatic load_limit(input cfg_index_t idx, input logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.write_limit(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every owed report has been popped, then lets the block settle.
    task automatic drain();
        push <= 1'b0;
        while (ledger.expected_reports.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic reconfigure(input logic [11:0] lo, input logic [11:0] hi,
                               input cfg_index_t spare);
        drain();
        load_limit(CfgRangeMin, lo);
        load_limit(CfgRangeMax, hi);
        // A write to an unused index must leave both limits as they are.
        load_limit(spare, 12'($urandom));
        drain();
    endtask

    // Shorts at every fill level of the history, a frame that starts with a kept
    // end byte, both range limits hit exactly, a bad checksum on an out-of-range
    // frame (the checksum must win), and a frame after surplus bytes have shifted
    // the history.
    task automatic run_directed();
        send_byte(8'h80);
        send_byte(8'h15);
        send_byte(8'hFF);
        send_byte(8'hC0);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_frame(12'd3, 13'd0, 1'b1);
        send_frame(12'd819, 13'd8191, 1'b1);
        send_frame(12'd2, 13'd4242, 1'b0);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_frame(12'd4095, 13'd5461, 1'b1);
    endtask

    // Mostly well-formed frames with random content and ranges around the current
    // limits; the rest is loose noise and frames cut short by an early end byte.
    task automatic send_random(input int quota);
        int          target;
        int          pick;
        logic [11:0] r;
        target = bytes_sent + quota;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) send_byte({1'b0, 7'($urandom)});
                case ($urandom_range(0, 3))
                    0:       r = ledger.range_min + 12'($urandom_range(0, 2)) - 12'd1;
                    1:       r = ledger.range_max + 12'($urandom_range(0, 2)) - 12'd1;
                    default: r = 12'($urandom);
                endcase
                send_frame(r, 13'($urandom), $urandom_range(0, 3) != 0);
            end
            else if (pick < 80)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            else
            begin
                repeat ($urandom_range(0, 2)) send_byte({1'b0, 7'($urandom)});
                send_byte({1'b1, 7'($urandom)});
            end
        end
    endtask

    // Main sequence: reset, directed bytes under the reset limits, then random
    // traffic under a series of limit settings, the extremes among them.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        send_random(PhaseBytes);

        reconfigure(12'd0, 12'd4095, CfgSpareLow);
        send_random(PhaseBytes);

        // Minimum above maximum: every frame with a good checksum is out of range.
        reconfigure(12'd4095, 12'd0, CfgSpareHigh);
        send_random(PhaseBytes);

        // This setting also runs without gaps on either side.
        reconfigure(12'd0, 12'd0, CfgSpareLow);
        steady = 1'b1;
        send_random(PhaseBytes);
        steady = 1'b0;

        reconfigure(12'd4095, 12'd4095, CfgSpareHigh);
        send_random(PhaseBytes);

        reconfigure(12'($urandom_range(0, 2047)), 12'($urandom_range(2048, 4095)),
                    CfgSpareLow);
        send_random(PhaseBytes);

        reconfigure(12'd3, 12'd819, CfgSpareHigh);
        send_random(PhaseBytes);

        drain();
        if (ledger.failures == 0 && ledger.expected_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
